@@ rtl/tlp_pkg.sv @@
// Package for the trace line parser: parse phases, status and kind codes,
// character codes and the structs passed between the parser modules.
// No dependencies.
package tlp_pkg;

  localparam int unsigned LineCharsDefault = 255;

  localparam int unsigned AddrW = 64;
  localparam int unsigned SizeW = 32;
  localparam int unsigned SizeAccW = 33;
  localparam int unsigned CountW = 32;

  typedef enum logic [3:0] {
    PH_LEAD     = 4'd0,
    PH_OPWS     = 4'd1,
    PH_SIGN     = 4'd2,
    PH_ZERO     = 4'd3,
    PH_DIGITS   = 4'd4,
    PH_PREFIX   = 4'd5,
    PH_SIZEWS   = 4'd6,
    PH_SIZESIGN = 4'd7,
    PH_SIZEDIG  = 4'd8,
    PH_DONE     = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    LS_RECORD    = 2'd0,
    LS_BLANK     = 2'd1,
    LS_MALFORMED = 2'd2
  } line_status_e;

  typedef enum logic [1:0] {
    AK_READ   = 2'd0,
    AK_WRITE  = 2'd1,
    AK_MODIFY = 2'd2
  } access_kind_e;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpI   = 8'h49;
  localparam logic [7:0] ChUpL   = 8'h4C;
  localparam logic [7:0] ChUpM   = 8'h4D;
  localparam logic [7:0] ChUpR   = 8'h52;
  localparam logic [7:0] ChUpS   = 8'h53;
  localparam logic [7:0] ChUpW   = 8'h57;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChLoX   = 8'h78;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic dig;
    logic pfx;
  } addr_flags_t;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic dig;
  } size_flags_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] text_byte;
    logic       end_of_text;
  } stage_t;

  typedef struct packed {
    logic                    close;
    line_status_e            status;
    access_kind_e            kind;
    logic [AddrW-1:0]        address;
    logic signed [SizeW-1:0] size;
  } line_result_t;

endpackage

@@ rtl/tlp_in_if.sv @@
// Input channel of the trace line parser: one text byte per transfer.
// Depends on nothing.
interface tlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ rtl/tlp_out_if.sv @@
// Output channel of the trace line parser: one parsed line per transfer.
// Depends on nothing.
interface tlp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         line_status;
  logic [1:0]         access_kind;
  logic [63:0]        address;
  logic signed [31:0] access_size;
  logic [31:0]        lines_seen;
  logic [31:0]        records_seen;
  logic [31:0]        skipped_seen;

  modport source (output valid, output line_status, output access_kind, output address,
                  output access_size, output lines_seen, output records_seen,
                  output skipped_seen, input ready);
  modport sink (input valid, input line_status, input access_kind, input address,
                input access_size, input lines_seen, input records_seen,
                input skipped_seen, output ready);
endinterface

@@ rtl/tlp_in_stage.sv @@
// Input register of the trace line parser: holds one text byte until the
// parse stage takes it. Depends on tlp_pkg.
module tlp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            adv_i,
  input  logic [7:0]      text_byte_i,
  input  logic            end_of_text_i,
  output tlp_pkg::stage_t stage_o
);
  import tlp_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       eot_q;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  assign stage_o = '{vld: vld_q, text_byte: byte_q, end_of_text: eot_q};
endmodule

@@ rtl/tlp_line_fsm.sv @@
// Per-byte line parser: phase register, address and size accumulators and
// the column count; reports each closed line. Depends on tlp_pkg.
module tlp_line_fsm #(
  parameter int unsigned LINE_CHARS = tlp_pkg::LineCharsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  tlp_pkg::stage_t       stage_i,
  output tlp_pkg::line_result_t result_o
);
  import tlp_pkg::*;

  localparam int unsigned ColW = $clog2(LINE_CHARS + 1);
  localparam logic [ColW-1:0] ColLimit = ColW'(LINE_CHARS);

  phase_e                phase_q, phase_d, ph;
  logic [ColW-1:0]       col_q, col_d, col_inc;
  access_kind_e          kind_q, kind_d, kind;
  line_status_e          status_q, status_d, status;
  logic [AddrW-1:0]      acc_q, acc_d, acc;
  addr_flags_t           af_q, af_d, af;
  logic [SizeAccW-1:0]   sacc_q, sacc_d, sacc;
  size_flags_t           sf_q, sf_d, sf;

  logic [7:0]            c, uc;
  logic                  is_sp, is_sign, is_dec, hv;
  logic [3:0]            hd;
  logic [SizeAccW+2:0]   dec_prod;
  logic                  close;
  line_status_e          fin_status;
  logic [AddrW-1:0]      fin_addr;
  logic [SizeW-1:0]      fin_size;

  assign c = stage_i.text_byte;

  always_comb begin
    uc = c;
    if (c >= ChLoA && c <= ChLoZ) begin
      uc = c - CaseGap;
    end
    is_sp = (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
            (c == ChFf) || (c == ChCr);
    is_sign = (c == ChPlus) || (c == ChMinus);
    is_dec = (c >= ChZero) && (c <= ChNine);
    hv = 1'b1;
    hd = 4'd0;
    if (is_dec) begin
      hd = 4'(c - ChZero);
    end else if (uc >= ChUpA && uc <= ChUpF) begin
      hd = 4'(uc - ChUpA + 8'd10);
    end else begin
      hv = 1'b0;
    end
    dec_prod = ({3'b000, sacc_q} << 3) + ({3'b000, sacc_q} << 1) +
               (SizeAccW+3)'(c - ChZero);
  end

  always_comb begin
    ph     = phase_q;
    kind   = kind_q;
    status = status_q;
    acc    = acc_q;
    af     = af_q;
    sacc   = sacc_q;
    sf     = sf_q;
    unique case (phase_q)
      PH_LEAD: begin
        if (c == ChSpace || c == ChTab) begin
          ph = PH_LEAD;
        end else if (c == ChNul || c == ChLf || c == ChCr || c == ChHash || c == ChEqual) begin
          status = LS_BLANK;
          ph     = PH_DONE;
        end else if (uc == ChUpR || uc == ChUpI || uc == ChUpL) begin
          kind = AK_READ;
          ph   = PH_OPWS;
        end else if (uc == ChUpW || uc == ChUpS) begin
          kind = AK_WRITE;
          ph   = PH_OPWS;
        end else if (uc == ChUpM) begin
          kind = AK_MODIFY;
          ph   = PH_OPWS;
        end else begin
          status = LS_MALFORMED;
          ph     = PH_DONE;
        end
      end
      PH_OPWS, PH_SIGN: begin
        if (phase_q == PH_OPWS && is_sp) begin
          ph = PH_OPWS;
        end else if (phase_q == PH_OPWS && is_sign) begin
          af.neg = (c == ChMinus);
          ph     = PH_SIGN;
        end else if (!hv) begin
          status = LS_MALFORMED;
          ph     = PH_DONE;
        end else begin
          af.dig = 1'b1;
          if (!af_q.ovf) begin
            if (acc_q[AddrW-1 -: 4] != 4'd0) begin
              af.ovf = 1'b1;
            end else begin
              acc = {acc_q[AddrW-5:0], hd};
            end
          end
          ph = (c == ChZero) ? PH_ZERO : PH_DIGITS;
        end
      end
      PH_ZERO, PH_DIGITS, PH_PREFIX: begin
        if (phase_q == PH_ZERO && (c == ChLoX || c == ChUpX)) begin
          af.pfx = 1'b1;
          ph     = PH_PREFIX;
        end else if (hv) begin
          af.dig = 1'b1;
          if (!af_q.ovf) begin
            if (acc_q[AddrW-1 -: 4] != 4'd0) begin
              af.ovf = 1'b1;
            end else begin
              acc = {acc_q[AddrW-5:0], hd};
            end
          end
          ph = PH_DIGITS;
        end else if (phase_q != PH_PREFIX && c == ChComma) begin
          ph = PH_SIZEWS;
        end else begin
          status = LS_RECORD;
          ph     = PH_DONE;
        end
      end
      PH_SIZEWS, PH_SIZESIGN, PH_SIZEDIG: begin
        if (phase_q == PH_SIZEWS && is_sp) begin
          ph = PH_SIZEWS;
        end else if (phase_q == PH_SIZEWS && is_sign) begin
          sf.neg = (c == ChMinus);
          ph     = PH_SIZESIGN;
        end else if (is_dec) begin
          sf.dig = 1'b1;
          if (!sf_q.ovf) begin
            if (dec_prod > (SizeAccW+3)'(36'h8000_0000)) begin
              sacc   = SizeAccW'(33'h0_8000_0000);
              sf.ovf = 1'b1;
            end else begin
              sacc = dec_prod[SizeAccW-1:0];
            end
          end
          ph = PH_SIZEDIG;
        end else begin
          status = LS_RECORD;
          ph     = PH_DONE;
        end
      end
      default: begin
        ph = phase_q;
      end
    endcase
  end

  assign col_inc = col_q + ColW'(1);
  assign close = (c == ChLf) || (col_inc >= ColLimit) || stage_i.end_of_text;

  always_comb begin
    if (ph == PH_DONE) begin
      fin_status = status;
    end else if (ph == PH_LEAD) begin
      fin_status = LS_BLANK;
    end else if (ph == PH_OPWS || ph == PH_SIGN) begin
      fin_status = LS_MALFORMED;
    end else begin
      fin_status = LS_RECORD;
    end

    if (af.ovf) begin
      fin_addr = '1;
    end else if (af.neg) begin
      fin_addr = '0 - acc;
    end else begin
      fin_addr = acc;
    end

    fin_size = '0;
    if (sf.dig) begin
      if (sf.neg) begin
        fin_size = (sacc >= SizeAccW'(33'h0_8000_0000)) ? 32'h8000_0000
                                                         : '0 - sacc[SizeW-1:0];
      end else begin
        fin_size = (sacc > SizeAccW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : sacc[SizeW-1:0];
      end
    end
  end

  always_comb begin
    result_o.close   = close;
    result_o.status  = fin_status;
    result_o.kind    = AK_READ;
    result_o.address = '0;
    result_o.size    = '0;
    if (fin_status == LS_RECORD) begin
      result_o.kind    = kind;
      result_o.address = fin_addr;
      result_o.size    = fin_size;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    col_d    = col_q;
    kind_d   = kind_q;
    status_d = status_q;
    acc_d    = acc_q;
    af_d     = af_q;
    sacc_d   = sacc_q;
    sf_d     = sf_q;
    if (adv_i) begin
      if (close) begin
        phase_d  = PH_LEAD;
        col_d    = '0;
        kind_d   = AK_READ;
        status_d = LS_RECORD;
        acc_d    = '0;
        af_d     = '0;
        sacc_d   = '0;
        sf_d     = '0;
      end else begin
        phase_d  = ph;
        col_d    = col_inc;
        kind_d   = kind;
        status_d = status;
        acc_d    = acc;
        af_d     = af;
        sacc_d   = sacc;
        sf_d     = sf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEAD;
      col_q    <= '0;
      kind_q   <= AK_READ;
      status_q <= LS_RECORD;
      acc_q    <= '0;
      af_q     <= '0;
      sacc_q   <= '0;
      sf_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      col_q    <= col_d;
      kind_q   <= kind_d;
      status_q <= status_d;
      acc_q    <= acc_d;
      af_q     <= af_d;
      sacc_q   <= sacc_d;
      sf_q     <= sf_d;
    end
  end
endmodule

@@ rtl/trace_line_parser_top.sv @@
// Top level of the trace line parser: input register, line parser, result
// register and running counts. Depends on tlp_pkg, tlp_in_if, tlp_out_if,
// tlp_in_stage and tlp_line_fsm.
//
// Usage: feed trace text on in_i one byte per transfer; mark the last byte
// of the text with end_of_text. A line closes on a newline byte, after
// LINE_CHARS bytes without one, or on the marked byte, and then one result
// (status, kind, address, size and the running line, record and skip
// counts including that line) appears on out_o. Bytes that do not close a
// line give no result.
// Throughput: one byte per cycle while no result stalls on out_o, set by the
// single parse step between the input register and the result register.
// Path: a byte taken on in_i waits in the input register until it is parsed;
// a result that it closes is held in the result register until it transfers.
// Stall: while a result waits on out_o, one more byte is still taken into
// the input register; further bytes wait until the result transfers.
// Reset: asynchronous, active low; clears the parse state, empties both
// registers and zeroes the counts.
module trace_line_parser_top #(
  parameter int unsigned LINE_CHARS = tlp_pkg::LineCharsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlp_in_if.sink    in_i,
  tlp_out_if.source out_o
);
  import tlp_pkg::*;

  stage_t           stage;
  line_result_t     res;
  logic             adv, load, emit;
  logic             out_vld_q, out_vld_d;
  line_status_e     status_q;
  access_kind_e     kind_q;
  logic [AddrW-1:0] addr_q;
  logic [SizeW-1:0] size_q;
  logic [CountW-1:0] lines_q, lines_d, recs_q, recs_d, skips_q, skips_d;

  assign adv  = stage.vld && (!out_vld_q || out_o.ready);
  assign load = in_i.valid && in_i.ready;
  assign emit = adv && res.close;
  assign in_i.ready = !stage.vld || adv;

  tlp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .adv_i        (adv),
    .text_byte_i  (in_i.text_byte),
    .end_of_text_i(in_i.end_of_text),
    .stage_o      (stage)
  );

  tlp_line_fsm #(
    .LINE_CHARS(LINE_CHARS)
  ) u_line_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .stage_i (stage),
    .result_o(res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    lines_d = lines_q;
    recs_d  = recs_q;
    skips_d = skips_q;
    if (emit) begin
      if (lines_q != '1) begin
        lines_d = lines_q + CountW'(1);
      end
      if (res.status == LS_RECORD) begin
        if (recs_q != '1) begin
          recs_d = recs_q + CountW'(1);
        end
      end else if (skips_q != '1) begin
        skips_d = skips_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      lines_q   <= '0;
      recs_q    <= '0;
      skips_q   <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      lines_q   <= lines_d;
      recs_q    <= recs_d;
      skips_q   <= skips_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= LS_RECORD;
      kind_q   <= AK_READ;
      addr_q   <= '0;
      size_q   <= '0;
    end else if (emit) begin
      status_q <= res.status;
      kind_q   <= res.kind;
      addr_q   <= res.address;
      size_q   <= res.size;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.line_status  = status_q;
  assign out_o.access_kind  = kind_q;
  assign out_o.address      = addr_q;
  assign out_o.access_size  = size_q;
  assign out_o.lines_seen   = lines_q;
  assign out_o.records_seen = recs_q;
  assign out_o.skipped_seen = skips_q;

  a_skip_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q != LS_RECORD |-> kind_q == AK_READ && addr_q == '0 && size_q == '0)
    else $error("non-record line carries payload");

  a_counts_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_q >= recs_q && lines_q >= skips_q)
    else $error("line count below record or skip count");

  a_lines_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && lines_q != '1 |=> lines_q == $past(lines_q) + CountW'(1))
    else $error("line count did not advance on a closed line");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |-> !emit)
    else $error("result overwritten while stalled");
endmodule
